// File: src/imuca_pkg.sv
// ----------------------------------------------------------------------------
// imuca_pkg
// Shared types and constants of the three-axis complementary attitude filter.
// ----------------------------------------------------------------------------
package imuca_pkg;

    localparam int NUM_LANES   = 3;
    localparam int BLEND_LANES = 2;          // X and Y take the accelerometer blend
    localparam int AXIS_W      = 32;
    localparam int TIME_W      = 32;
    localparam int WEIGHT_W    = 17;

    // Reciprocal division: 64-bit dividend, one 32x32 partial product per cycle
    localparam int DIVIDEND_W  = 64;
    localparam int DIV_CYCLES  = 4;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE         = 17'd65536;
    localparam logic [WEIGHT_W-1:0] ACC_STRENGTH_RESET = 17'd3277;

    localparam logic       MODE_GYRO  = 1'b0;
    localparam logic       MODE_ACCEL = 1'b1;

    localparam int         ADDR_W            = 3;
    localparam logic [2:0] ADDR_ACC_STRENGTH = 3'd0;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SEED,
        OP_INTEG,
        OP_BLEND
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 load;
        state_t               state;
        op_t                  op;
        logic [DIV_CNT_W-1:0] step;
    } lane_ctl_t;

    typedef struct packed {
        logic commit;
        op_t  op;
    } merge_ctl_t;

endpackage

// File: src/imu_complementary_attitude.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// Three-axis complementary attitude filter: gyro integration over timestamp
// deltas and accelerometer blending, signed Q16.16, saturating.
//
//   Port group   Dir   Contents
//   s_*          in    tuser: mode; tdata: sample_x, sample_y, sample_z, time_us
//   m_*          out   tuser: ready_res; tdata: angle_x, angle_y, angle_z
//   p*           in    acc_strength at byte address 0
//
// A seed or an ignored gyro sample goes straight to the done step; a blend
// takes multiply and saturate; gyro integration adds rounding and the division
// by TICKS_PER_SECOND as a reciprocal multiply in four 32x32 partial products.
// One transaction is in work at a time; the next is taken while a result waits.
// Reset is asynchronous, active low; angles, flags and timestamp clear to zero.
// A stalled output holds the sequencer in its final step until taken.
// ----------------------------------------------------------------------------
module imu_complementary_attitude
    import imuca_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [4*32-1:0]             s_tdata,   // sample_x, sample_y, sample_z, time_us
    input  logic                        s_tuser,   // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [NUM_LANES*AXIS_W-1:0] m_tdata,   // angle_x, angle_y, angle_z
    output logic                        m_tuser,   // ready_res
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    lane_ctl_t                        lane_ctl;
    merge_ctl_t                       merge_ctl;
    logic                             seeded;
    logic                             out_free;
    logic [TIME_W-1:0]                ticks;
    logic [WEIGHT_W-1:0]              weight;
    logic [NUM_LANES-1:0][AXIS_W-1:0] angles;
    logic [NUM_LANES-1:0][AXIS_W-1:0] lane_held;
    logic [NUM_LANES-1:0][AXIS_W-1:0] lane_result;

    imuca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tuser),
        .time_us   (s_tdata[NUM_LANES*AXIS_W +: TIME_W]),
        .out_free  (out_free),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .lane_ctl  (lane_ctl),
        .merge_ctl (merge_ctl),
        .seeded    (seeded),
        .ticks     (ticks),
        .weight    (weight)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        imuca_lane #(
            .TICKS_PER_SECOND (TICKS_PER_SECOND)
        ) u_lane (
            .clk    (clk),
            .ctl    (lane_ctl),
            .sample (s_tdata[i*AXIS_W +: AXIS_W]),
            .angle  (angles[i]),
            .ticks  (ticks),
            .weight (weight),
            .held   (lane_held[i]),
            .result (lane_result[i])
        );
    end

    imuca_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (merge_ctl),
        .seeded      (seeded),
        .lane_held   (lane_held),
        .lane_result (lane_result),
        .angles      (angles),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// File: src/imuca_lane.sv
// ----------------------------------------------------------------------------
// imuca_lane
// One axis: shared signed multiplier, division by the tick rate through a
// reciprocal multiply in four partial products, and the saturating update of
// the angle.
// ----------------------------------------------------------------------------
module imuca_lane
    import imuca_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000
)
(
    input  logic                       clk,
    input  lane_ctl_t                  ctl,
    input  logic signed [AXIS_W-1:0]   sample,
    input  logic signed [AXIS_W-1:0]   angle,
    input  logic        [TIME_W-1:0]   ticks,
    input  logic        [WEIGHT_W-1:0] weight,
    output logic signed [AXIS_W-1:0]   held,
    output logic signed [AXIS_W-1:0]   result
);

    // floor(n / TICKS_PER_SECOND) is exact for every n below BIG_LIMIT when n is
    // multiplied by ceil(2^RECIP_K / TICKS_PER_SECOND) and RECIP_K bits are dropped
    localparam int DIV_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int Q_W     = AXIS_W + 1;
    localparam int RECIP_K = (2 * DIV_W + Q_W > 64) ? 2 * DIV_W + Q_W : 64;
    localparam int Q_SHIFT = RECIP_K - 64;
    localparam int ACC_W   = DIVIDEND_W + 2;
    localparam logic [127:0] RECIP_FULL =
        ((128'd1 << RECIP_K) + 128'(TICKS_PER_SECOND) - 128'd1) / 128'(TICKS_PER_SECOND);
    localparam logic [DIVIDEND_W-1:0]   RECIP     = RECIP_FULL[DIVIDEND_W-1:0];
    localparam logic [DIVIDEND_W-1:0]   HALF      = DIVIDEND_W'(TICKS_PER_SECOND / 2);
    localparam logic [DIVIDEND_W-1:0]   BIG_LIMIT = DIVIDEND_W'(TICKS_PER_SECOND) << Q_W;
    localparam logic signed [AXIS_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [AXIS_W-1:0] S32_MIN = 32'sh8000_0000;

    logic signed [AXIS_W-1:0]     sample_reg;
    logic                         neg_reg;
    logic        [DIVIDEND_W-1:0] prod_reg;
    logic        [DIVIDEND_W-1:0] num_reg;
    logic                         big_reg;
    logic        [ACC_W-1:0]      acc_reg;
    logic signed [AXIS_W-1:0]     result_reg;

    logic signed [AXIS_W:0]       op_a;
    logic signed [AXIS_W:0]       op_b;
    logic signed [2*AXIS_W+1:0]   prod;
    logic        [DIVIDEND_W-1:0] num_sum;
    logic        [31:0]           recip_a;
    logic        [31:0]           recip_b;
    logic        [63:0]           recip_pp;
    logic        [ACC_W-1:0]      acc_next;
    logic        [Q_W-1:0]        quot;
    logic signed [AXIS_W-1:0]     sat_next;

    function automatic logic signed [AXIS_W-1:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF)
            return S32_MAX;
        else if (v < -36'sh0_8000_0000)
            return S32_MIN;
        else
            return v[AXIS_W-1:0];
    endfunction

    // Multiplier operands: |rate| x ticks, or (sample - angle) x weight
    always_comb
    begin
        logic signed [AXIS_W:0] s_ext;
        logic signed [AXIS_W:0] a_ext;
        s_ext = {sample_reg[AXIS_W-1], sample_reg};
        a_ext = {angle[AXIS_W-1], angle};
        case (ctl.op)
            OP_INTEG:
            begin
                op_a = sample_reg[AXIS_W-1] ? -s_ext : s_ext;
                op_b = {1'b0, ticks};
            end
            default:
            begin
                op_a = s_ext - a_ext;
                op_b = {{(AXIS_W + 1 - WEIGHT_W){1'b0}}, weight};
            end
        endcase
    end

    assign prod = (2*AXIS_W+2)'(op_a) * (2*AXIS_W+2)'(op_b);

    assign num_sum = prod_reg + HALF;

    // Partial products low half first; drop 32 bits after each half of RECIP
    always_comb
    begin
        recip_a = ctl.step[1] ? num_reg[63:32] : num_reg[31:0];
        recip_b = ctl.step[0] ? RECIP[63:32] : RECIP[31:0];
    end

    assign recip_pp = {32'd0, recip_a} * {32'd0, recip_b};

    always_comb
    begin
        if (ctl.step == '0)
            acc_next = {2'b00, recip_pp};
        else if (ctl.step[0])
            acc_next = {32'd0, acc_reg[ACC_W-1:32]} + {2'b00, recip_pp};
        else
            acc_next = acc_reg + {2'b00, recip_pp};
    end

    assign quot = acc_reg[Q_SHIFT +: Q_W];

    // Final add and saturation
    always_comb
    begin
        logic signed [34:0] inc;
        logic signed [35:0] sum;
        logic signed [49:0] bl;
        inc = '0;
        sum = '0;
        bl  = '0;
        case (ctl.op)
            OP_INTEG:
            begin
                inc = neg_reg ? -$signed({2'b00, quot})
                              :  $signed({2'b00, quot});
                sum = 36'(angle) + 36'(inc);
                if (big_reg)
                    sat_next = neg_reg ? S32_MIN : S32_MAX;
                else
                    sat_next = sat32(sum);
            end
            default:
            begin
                bl  = $signed(prod_reg[49:0]) + 50'sd32768;
                sum = 36'(angle) + {{2{bl[49]}}, bl[49:16]};
                sat_next = sat32(sum);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            sample_reg <= sample;
        case (ctl.state)
            ST_MUL:
            begin
                prod_reg <= prod[DIVIDEND_W-1:0];
                neg_reg  <= sample_reg[AXIS_W-1];
            end
            ST_RND:
            begin
                num_reg <= num_sum;
                big_reg <= (num_sum >= BIG_LIMIT);
            end
            ST_DIV:
            begin
                acc_reg <= acc_next;
            end
            ST_SAT:
            begin
                result_reg <= sat_next;
            end
            default:
            begin
            end
        endcase
    end

    assign held   = sample_reg;
    assign result = result_reg;

endmodule

// File: src/imuca_ctrl.sv
// ----------------------------------------------------------------------------
// imuca_ctrl
// Sequencer, timestamp and seed state, and the register port.
// ----------------------------------------------------------------------------
module imuca_ctrl
    import imuca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                mode,
    input  logic [TIME_W-1:0]   time_us,
    input  logic                out_free,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output lane_ctl_t           lane_ctl,
    output merge_ctl_t          merge_ctl,
    output logic                seeded,
    output logic [TIME_W-1:0]   ticks,
    output logic [WEIGHT_W-1:0] weight
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [TIME_W-1:0]      last_time_reg, last_time_next;
    logic                   time_seen_reg, time_seen_next;
    logic                   seeded_reg, seeded_next;
    logic [TIME_W-1:0]      ticks_reg, ticks_next;
    logic [WEIGHT_W-1:0]    acc_strength_reg;
    logic                   accept;
    logic                   commit;

    assign accept = s_tvalid && s_tready;

    // Classify the transaction and update the timestamp and seed flags
    always_comb
    begin
        op_next        = op_reg;
        last_time_next = last_time_reg;
        time_seen_next = time_seen_reg;
        seeded_next    = seeded_reg;
        ticks_next     = ticks_reg;
        if (accept)
        begin
            op_next = OP_NONE;
            if (mode == MODE_GYRO)
            begin
                if (!time_seen_reg)
                begin
                    last_time_next = time_us;
                    time_seen_next = 1'b1;
                end
                else if (seeded_reg)
                begin
                    op_next        = OP_INTEG;
                    ticks_next     = time_us - last_time_reg;
                    last_time_next = time_us;
                end
            end
            else
            begin
                if (!seeded_reg)
                begin
                    op_next     = OP_SEED;
                    seeded_next = 1'b1;
                end
                else
                begin
                    op_next = OP_BLEND;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (op_next == OP_INTEG || op_next == OP_BLEND) ? ST_MUL
                                                                              : ST_DONE;
            end
            ST_MUL:  state_next = (op_reg == OP_INTEG) ? ST_RND : ST_SAT;
            ST_RND:  state_next = ST_DIV;
            ST_DIV:  state_next = (div_cnt_reg == DIV_LAST) ? ST_SAT : ST_DIV;
            ST_SAT:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        commit       = 1'b0;
        div_cnt_next = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DIV:  div_cnt_next = div_cnt_reg + 1'b1;
            ST_DONE: commit = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_NONE;
            div_cnt_reg      <= '0;
            last_time_reg    <= '0;
            time_seen_reg    <= 1'b0;
            seeded_reg       <= 1'b0;
            ticks_reg        <= '0;
            acc_strength_reg <= ACC_STRENGTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            div_cnt_reg   <= div_cnt_next;
            last_time_reg <= last_time_next;
            time_seen_reg <= time_seen_next;
            seeded_reg    <= seeded_next;
            ticks_reg     <= ticks_next;
            if (psel && penable && pwrite && pready && paddr == ADDR_ACC_STRENGTH)
                acc_strength_reg <= pwdata[WEIGHT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ACC_STRENGTH) ? {{(32 - WEIGHT_W){1'b0}}, acc_strength_reg}
                                                 : 32'd0;

    // Clamp the blend weight to one
    assign weight = (acc_strength_reg > WEIGHT_ONE) ? WEIGHT_ONE : acc_strength_reg;
    assign ticks  = ticks_reg;
    assign seeded = seeded_reg;

    assign lane_ctl.load   = accept;
    assign lane_ctl.state  = state_reg;
    assign lane_ctl.op     = op_reg;
    assign lane_ctl.step   = div_cnt_reg;
    assign merge_ctl.commit = commit;
    assign merge_ctl.op     = op_reg;

    a_rnd_only_integ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND || state_reg == ST_DIV) |-> (op_reg == OP_INTEG))
        else $error("divider running for a non-integrating transaction");

    a_sat_has_math: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT) |-> (op_reg == OP_INTEG || op_reg == OP_BLEND))
        else $error("saturation step without arithmetic");

    a_accel_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_ACCEL) |=> seeded_reg)
        else $error("accelerometer transaction left angles unseeded");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> out_free)
        else $error("result committed into a full output register");

endmodule

// File: src/imuca_merge.sv
// ----------------------------------------------------------------------------
// imuca_merge
// Combines the lane results into the angle store and holds the output
// transaction until it is taken.
// ----------------------------------------------------------------------------
module imuca_merge
    import imuca_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  merge_ctl_t                          ctl,
    input  logic                                seeded,
    input  logic [NUM_LANES-1:0][AXIS_W-1:0]    lane_held,
    input  logic [NUM_LANES-1:0][AXIS_W-1:0]    lane_result,
    output logic [NUM_LANES-1:0][AXIS_W-1:0]    angles,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [NUM_LANES*AXIS_W-1:0]         m_tdata,
    output logic                                m_tuser
);

    logic [NUM_LANES-1:0][AXIS_W-1:0] angle_store_reg;
    logic [NUM_LANES-1:0][AXIS_W-1:0] angle_store_next;
    logic                             m_tvalid_reg;
    logic [NUM_LANES*AXIS_W-1:0]      m_tdata_reg;
    logic                             m_tuser_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            case (ctl.op)
                OP_SEED:  angle_store_next[i] = lane_held[i];
                OP_INTEG: angle_store_next[i] = lane_result[i];
                OP_BLEND: angle_store_next[i] = (i < BLEND_LANES) ? lane_result[i]
                                                                  : angle_store_reg[i];
                default:  angle_store_next[i] = angle_store_reg[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_store_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else if (ctl.commit)
        begin
            angle_store_reg <= angle_store_next;
            m_tvalid_reg    <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            m_tdata_reg <= angle_store_next;
            m_tuser_reg <= seeded;
        end
    end

    assign angles   = angle_store_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> (m_tvalid_reg && m_tdata_reg == angle_store_reg))
        else $error("committed result does not match the angle store");

    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("nonzero angles reported before seeding");

    a_none_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && ctl.op == OP_NONE) |=> $stable(angle_store_reg))
        else $error("angle store changed on a pass-through transaction");

endmodule

// File: test/imu_complementary_attitude_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_test
// Self-checking bench for the complementary attitude filter. A scoreboard
// class tracks angles, seeding, timestamp and blend weight, and predicts the
// attitude after every accepted sample. Directed samples cover the extremes,
// first-gyro and unseeded cases, rounding, wrap and weight clamping. Random
// phases with several weights follow. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_test;
    import imuca_pkg::*;

    localparam int TPS           = 1000000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 380;
    localparam int NUM_PHASES    = 5;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [AXIS_W-1:0] ang_z;
        logic signed [AXIS_W-1:0] ang_y;
        logic signed [AXIS_W-1:0] ang_x;
        logic                     rdy;
    } attitude_t;

    class attitude_tracker;
        logic signed [AXIS_W-1:0] ang [NUM_LANES];
        bit                       seeded;
        bit                       time_seen;
        logic [TIME_W-1:0]        last_us;
        logic [WEIGHT_W-1:0]      weight;
        attitude_t                attitude_due [$];
        int                       mismatches;

        function new();
            for (int i = 0; i < NUM_LANES; i++)
                ang[i] = '0;
            seeded     = 1'b0;
            time_seen  = 1'b0;
            last_us    = '0;
            weight     = ACC_STRENGTH_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return attitude_due.size();
        endfunction

        function logic signed [AXIS_W-1:0] sat_s32(logic signed [63:0] v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        // angle + |rate|*ticks/TPS, rounded half away from zero, signed as the rate
        function logic signed [AXIS_W-1:0] integrate_axis(logic signed [AXIS_W-1:0] a,
                                                          logic signed [AXIS_W-1:0] rate,
                                                          logic [TIME_W-1:0] ticks);
            logic signed [63:0] r64;
            logic signed [63:0] a64;
            logic signed [63:0] inc;
            logic [63:0]        mag;
            logic [63:0]        q;
            r64 = rate;
            a64 = a;
            mag = (r64 < 0) ? -r64 : r64;
            mag = mag * {32'd0, ticks};
            q   = (mag + 64'(TPS / 2)) / 64'(TPS);
            inc = (r64 < 0) ? -$signed(q) : $signed(q);
            return sat_s32(a64 + inc);
        endfunction

        function logic signed [AXIS_W-1:0] blend_axis(logic signed [AXIS_W-1:0] a,
                                                      logic signed [AXIS_W-1:0] smp,
                                                      logic [WEIGHT_W-1:0] w);
            logic signed [63:0] a64;
            logic signed [63:0] s64;
            logic signed [63:0] wa;
            logic signed [63:0] wb;
            logic signed [63:0] t;
            a64 = a;
            s64 = smp;
            wa  = {47'd0, w};
            wb  = 64'sd65536 - wa;
            t   = a64 * wb + s64 * wa + 64'sd32768;
            return sat_s32(t >>> 16);
        endfunction

        function void note_sample(logic mode, logic [4*32-1:0] data);
            logic signed [AXIS_W-1:0] smp [NUM_LANES];
            logic [TIME_W-1:0]        now_us;
            logic [WEIGHT_W-1:0]      w;
            attitude_t                res;
            for (int i = 0; i < NUM_LANES; i++)
                smp[i] = data[i*AXIS_W +: AXIS_W];
            now_us = data[3*AXIS_W +: TIME_W];
            w      = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
            if (mode == MODE_GYRO)
            begin
                if (!time_seen)
                begin
                    last_us   = now_us;
                    time_seen = 1'b1;
                end
                else if (seeded)
                begin
                    for (int i = 0; i < NUM_LANES; i++)
                        ang[i] = integrate_axis(ang[i], smp[i], now_us - last_us);
                    last_us = now_us;
                end
            end
            else if (!seeded)
            begin
                for (int i = 0; i < NUM_LANES; i++)
                    ang[i] = smp[i];
                seeded = 1'b1;
            end
            else
            begin
                for (int i = 0; i < BLEND_LANES; i++)
                    ang[i] = blend_axis(ang[i], smp[i], w);
            end
            res.ang_x = ang[0];
            res.ang_y = ang[1];
            res.ang_z = ang[2];
            res.rdy   = seeded;
            attitude_due.push_back(res);
        endfunction

        function void check_attitude(logic [NUM_LANES*AXIS_W-1:0] tdata, logic tuser);
            attitude_t got;
            attitude_t want;
            got.ang_x = tdata[0*AXIS_W +: AXIS_W];
            got.ang_y = tdata[1*AXIS_W +: AXIS_W];
            got.ang_z = tdata[2*AXIS_W +: AXIS_W];
            got.rdy   = tuser;
            if (attitude_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%h y=%h z=%h rdy=%b",
                             got.ang_x, got.ang_y, got.ang_z, got.rdy);
                return;
            end
            want = attitude_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("attitude mismatch: exp x=%h y=%h z=%h rdy=%b, got x=%h y=%h z=%h rdy=%b",
                             want.ang_x, want.ang_y, want.ang_z, want.rdy,
                             got.ang_x, got.ang_y, got.ang_z, got.rdy);
            end
        endfunction
    endclass

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [4*32-1:0]             s_tdata  = '0;    // sample_x, sample_y, sample_z, time_us
    logic                        s_tuser  = 1'b0;  // mode
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [NUM_LANES*AXIS_W-1:0] m_tdata;          // angle_x, angle_y, angle_z
    logic                        m_tuser;          // ready_res
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [ADDR_W-1:0]           paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    attitude_tracker sb;
    bit              steady     = 1'b0;
    logic [31:0]     stamp_us   = '0;
    int              idle_cycles = 0;

    imu_complementary_attitude #(
        .TICKS_PER_SECOND (TPS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_attitude(m_tdata, m_tuser);
        m_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("imu_complementary_attitude_test failed");
            $finish;
        end
    end

    task automatic send_sample(input logic mode, input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz, input logic [31:0] t_us);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 21)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {t_us, sz, sy, sx};
        do @(posedge clk); while (!s_tready);
        sb.note_sample(mode, {t_us, sz, sy, sx});
    endtask

    // Hold the sender until every predicted attitude has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACC_STRENGTH;
        pwdata  <= {15'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.weight = value;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_rate();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 32'h007f_ffff) - 32'h0040_0000;
        return $urandom;
    endfunction

    // Mostly +-90 degrees, sometimes anything
    function automatic logic [31:0] pick_angle();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 11796480) - 32'd5898240;
        return $urandom;
    endfunction

    task automatic send_random();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            send_sample(MODE_ACCEL, pick_angle(), pick_angle(), pick_angle(), $urandom);
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                stamp_us = stamp_us + $urandom_range(0, 20000);
            else if (roll < 95)
                stamp_us = $urandom;
            send_sample(MODE_GYRO, pick_rate(), pick_rate(), pick_rate(), stamp_us);
        end
    endtask

    initial
    begin
        logic [WEIGHT_W-1:0] w;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first gyro only takes the timestamp, the next one is dropped while unseeded
        send_sample(MODE_GYRO, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'd100);
        send_sample(MODE_GYRO, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd9000);
        send_sample(MODE_ACCEL, 32'h7fffffff, 32'h80000000, 32'h00b40000, 32'hffffffff);
        // two seconds of full-scale rate: saturate both ways
        send_sample(MODE_GYRO, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd2000100);
        // half a tick of rate: round half away from zero
        send_sample(MODE_GYRO, 32'h00000001, 32'hffffffff, 32'h00000000, 32'd2500100);
        send_sample(MODE_GYRO, 32'h12345678, 32'hedcba988, 32'h7fffffff, 32'd2500100);
        send_sample(MODE_GYRO, 32'h00010000, 32'hffff0000, 32'h00008000, 32'hffffff00);
        // timestamp wraps past zero
        send_sample(MODE_GYRO, 32'h00400000, 32'hffc00000, 32'h80000000, 32'h00000100);
        send_sample(MODE_ACCEL, 32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000000);
        send_sample(MODE_ACCEL, 32'h00000000, 32'h00000000, 32'h7fffffff, 32'h55555555);
        send_sample(MODE_ACCEL, 32'hffffffff, 32'h00000001, 32'haaaaaaaa, 32'haaaaaaaa);
        write_weight(WEIGHT_ONE);
        send_sample(MODE_ACCEL, 32'h11110000, 32'heeee0000, 32'h00000000, 32'h0);
        send_sample(MODE_ACCEL, 32'h7fffffff, 32'h80000000, 32'h12345678, 32'h0);
        // weight above one clamps to one
        write_weight(17'h1ffff);
        send_sample(MODE_ACCEL, 32'h00c80000, 32'hff380000, 32'h00000000, 32'h0);
        write_weight('0);
        send_sample(MODE_ACCEL, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0);
        // longest possible interval at the most negative rate
        send_sample(MODE_GYRO, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h000000ff);
        send_sample(MODE_GYRO, 32'h00000000, 32'h00000000, 32'h00000000, 32'h000000ff);
        stamp_us = 32'h000000ff;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: w = 17'($urandom_range(0, 65536));
                1: w = WEIGHT_ONE;
                2: w = '0;
                3: w = 17'($urandom_range(0, 8000));
                default: w = 17'($urandom_range(65537, 131071));
            endcase
            write_weight(w);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                steady <= (phase == 1) && (i >= 60) && (i < 300);
                if (phase == 2 && i == PHASE_ITEMS / 2)
                    drain_results();
                send_random();
            end
            steady <= 1'b0;
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("imu_complementary_attitude_test passed");
        else
            $display("imu_complementary_attitude_test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/imuca_pkg.sv
src/imuca_lane.sv
src/imuca_ctrl.sv
src/imuca_merge.sv
src/imu_complementary_attitude.sv
test/imu_complementary_attitude_test.sv
